// ===== hw/rtl/key_debounce_short_long_press_macros.svh =====
// Assertion macros for the key debounce and press classifier.
`ifndef KEY_DEBOUNCE_SHORT_LONG_PRESS_MACROS_SVH
`define KEY_DEBOUNCE_SHORT_LONG_PRESS_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define KDSLP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define KDSLP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/kdslp_pkg.sv =====
// Shared constants, codes, types and the key priority encoder.
`timescale 1ns / 1ps
`default_nettype none
package kdslp_pkg;

   localparam int NUM_KEYS      = 7;
   localparam int LEVELS_W      = 7;
   localparam int KEY_ID_W      = 3;
   localparam int EVENT_W       = 2;
   localparam int BEEP_W        = 2;
   localparam int DEBOUNCE_W    = 8;
   localparam int LONG_W        = 16;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 16;
   localparam int REQ_TDATA_W   = 8;
   localparam int RSP_TDATA_W   = 8;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(5);
   localparam logic [LONG_W-1:0]     LONG_RESET     = LONG_W'(1600);

   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG     = 1'b1;

   localparam logic [1:0] PHASE_IDLE     = 2'd0;
   localparam logic [1:0] PHASE_DEBOUNCE = 2'd1;
   localparam logic [1:0] PHASE_HELD     = 2'd2;

   localparam logic [EVENT_W-1:0] EVENT_NONE    = 2'd0;
   localparam logic [EVENT_W-1:0] EVENT_SHORT   = 2'd1;
   localparam logic [EVENT_W-1:0] EVENT_LONG    = 2'd2;
   localparam logic [EVENT_W-1:0] EVENT_RELEASE = 2'd3;

   localparam logic [BEEP_W-1:0] BEEP_NONE   = 2'd0;
   localparam logic [BEEP_W-1:0] BEEP_SINGLE = 2'd1;
   localparam logic [BEEP_W-1:0] BEEP_DOUBLE = 2'd2;

   typedef struct packed {
      logic [DEBOUNCE_W-1:0] debounce_ticks;
      logic [LONG_W-1:0]     long_press_ticks;
   } cfg_type;

   typedef struct packed {
      logic [BEEP_W-1:0]   beep_request;
      logic [KEY_ID_W-1:0] key_id;
      logic [EVENT_W-1:0]  event_res;
   } result_type;

   function automatic logic [KEY_ID_W-1:0] priority_key(input logic [NUM_KEYS-1:0] pressed);
      logic [KEY_ID_W-1:0] id;
      id = '0;
      for (int i = NUM_KEYS - 1; i >= 0; i--) begin
         if (pressed[i]) begin
            id = KEY_ID_W'(i + 1);
         end
      end
      return id;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/kdslp_csr.sv =====
// Configuration registers for debounce and long-press thresholds.
`timescale 1ns / 1ps
`default_nettype none
module kdslp_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [kdslp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [kdslp_pkg::CSR_DATA_W-1:0]     csr_data,
   output kdslp_pkg::cfg_type                        cfg
);
   import kdslp_pkg::*;

   logic [DEBOUNCE_W-1:0] debounce_ff, debounce_in;
   logic [LONG_W-1:0]     long_ff, long_in;

   assign csr_ready = 1'b1;

   always_comb begin
      debounce_in = debounce_ff;
      long_in     = long_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_DEBOUNCE: debounce_in = csr_data[DEBOUNCE_W-1:0];
            REG_LONG:     long_in     = csr_data[LONG_W-1:0];
            default: begin
               debounce_in = debounce_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         long_ff     <= LONG_RESET;
      end else begin
         debounce_ff <= debounce_in;
         long_ff     <= long_in;
      end
   end

   assign cfg.debounce_ticks   = debounce_ff;
   assign cfg.long_press_ticks = long_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/kdslp_core.sv =====
// Press state machine: phase, saturating hold count, latched key, per-item result.
`timescale 1ns / 1ps
`default_nettype none
module kdslp_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic [kdslp_pkg::LEVELS_W-1:0]    key_levels,
   input  wire kdslp_pkg::cfg_type                cfg,
   output kdslp_pkg::result_type                  result
);
   import kdslp_pkg::*;

   logic [1:0]          phase_ff, phase_in;
   logic [LONG_W-1:0]   count_ff, count_in;
   logic [KEY_ID_W-1:0] key_ff, key_in;

   logic [NUM_KEYS-1:0] pressed;
   logic                any_pressed;
   logic [1:0]          phase_cur;
   logic [LONG_W-1:0]   count_cur, count_inc;
   logic [KEY_ID_W-1:0] key_cur, key_pick;
   logic                reach_debounce, reach_long;

   assign pressed     = ~key_levels[NUM_KEYS-1:0];
   assign any_pressed = |pressed;
   assign key_pick    = priority_key(pressed);

   always_comb begin
      phase_cur = phase_ff;
      count_cur = count_ff;
      key_cur   = key_ff;
      if (phase_ff != PHASE_IDLE && phase_ff != PHASE_DEBOUNCE && phase_ff != PHASE_HELD) begin
         phase_cur = PHASE_IDLE;
         count_cur = '0;
         key_cur   = '0;
      end
   end

   assign count_inc      = (&count_cur) ? count_cur : count_cur + LONG_W'(1);
   assign reach_debounce = count_inc >= LONG_W'(cfg.debounce_ticks);
   assign reach_long     = count_inc >= cfg.long_press_ticks;

   always_comb begin
      phase_in = phase_cur;
      count_in = count_cur;
      key_in   = key_cur;
      result   = '{beep_request: BEEP_NONE, key_id: '0, event_res: EVENT_NONE};
      unique case (phase_cur)
         PHASE_HELD: begin
            count_in = count_inc;
            if (reach_long) begin
               result.key_id       = key_cur;
               result.beep_request = BEEP_DOUBLE;
               if (!any_pressed) begin
                  result.event_res = EVENT_RELEASE;
                  phase_in = PHASE_IDLE;
                  count_in = '0;
                  key_in   = '0;
               end else begin
                  result.event_res = EVENT_LONG;
               end
            end else if (!any_pressed) begin
               result.event_res    = EVENT_SHORT;
               result.key_id       = key_cur;
               result.beep_request = BEEP_SINGLE;
               phase_in = PHASE_IDLE;
               count_in = '0;
               key_in   = '0;
            end
         end
         default: begin
            if (phase_cur == PHASE_DEBOUNCE || any_pressed) begin
               if (!any_pressed) begin
                  phase_in = PHASE_IDLE;
                  count_in = '0;
                  key_in   = '0;
               end else begin
                  count_in = count_inc;
                  phase_in = PHASE_DEBOUNCE;
                  if (reach_debounce) begin
                     phase_in = PHASE_HELD;
                     key_in   = key_pick;
                     if (reach_long) begin
                        result.event_res    = EVENT_LONG;
                        result.key_id       = key_pick;
                        result.beep_request = BEEP_DOUBLE;
                     end
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         count_ff <= '0;
         key_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         key_ff   <= key_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/key_debounce_short_long_press.sv =====
// Top level: input register, press state machine, result register, config port.
//
//   channel | dir | handshake              | payload
//   req     | in  | req_tvalid/req_tready  | req_tdata: key_levels
//   rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata: event_res, key_id, beep_request
//   csr     | in  | csr_valid/csr_ready    | csr_index, csr_data
//
// One item per cycle while rsp is not stalled; an item is held in the input register,
// then its result is captured in the result register and shows on rsp from there.
// The state machine updates as an item moves from the input to the result register.
// Reset clears phase, hold count, latched key and all valids, and restores both
// thresholds to their defaults.
// A stalled rsp holds the result; req takes one more item, then stalls.
`timescale 1ns / 1ps
`default_nettype none
`include "key_debounce_short_long_press_macros.svh"
module key_debounce_short_long_press (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [kdslp_pkg::REQ_TDATA_W-1:0]     req_tdata,  // [6:0] key_levels, [7] zero
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [kdslp_pkg::RSP_TDATA_W-1:0]          rsp_tdata,  // [1:0] event_res,
                                                                  // [4:2] key_id,
                                                                  // [6:5] beep_request, [7] zero
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [kdslp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [kdslp_pkg::CSR_DATA_W-1:0]      csr_data
);
   import kdslp_pkg::*;

   cfg_type    cfg;
   result_type step_result;

   logic                in_valid_ff, in_valid_in;
   logic [LEVELS_W-1:0] in_levels_ff;
   logic                out_valid_ff, out_valid_in;
   result_type          out_data_ff;
   logic                advance;

   kdslp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   kdslp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .key_levels (in_levels_ff),
      .cfg        (cfg),
      .result     (step_result)
   );

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_levels_ff <= req_tdata[LEVELS_W-1:0];
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(out_data_ff);

   `KDSLP_ASSERT_NOW(a_event_has_key, clock, reset,
      rsp_tvalid && out_data_ff.event_res != EVENT_NONE, out_data_ff.key_id != '0,
      "event without latched key")
   `KDSLP_ASSERT_NOW(a_long_double_beep, clock, reset,
      rsp_tvalid && (out_data_ff.event_res == EVENT_LONG ||
                     out_data_ff.event_res == EVENT_RELEASE),
      out_data_ff.beep_request == BEEP_DOUBLE,
      "long press without double beep")
   `KDSLP_ASSERT_NEXT(a_step_fills_output, clock, reset,
      advance, rsp_tvalid,
      "stepped item missing from output")

endmodule
`default_nettype wire
